@@ sv/rlepsd_pkg.sv @@
// Shared types and constants for the run-length palette sprite line decoder.
// Used by rlepsd_palette_ram, rlepsd_pixel and rle_palette_sprite_line_decoder. No dependencies.
package rlepsd_pkg;

  localparam int unsigned LINE_MAX    = 4096;  // widest line the decoder clamps to
  localparam int unsigned LEN_W       = 13;    // run length and line width bits
  localparam int unsigned PAL_DEPTH   = 256;
  localparam int unsigned PAL_ADDR_W  = $clog2(PAL_DEPTH);
  localparam int unsigned COLOR_W     = 16;    // RGB565
  localparam int unsigned PIX_W       = 32;    // ABGR8888
  localparam int unsigned LINE_RESET  = 640;

  // Request function carried in tuser
  localparam logic [1:0] FUNC_PAL_WR    = 2'd0;
  localparam logic [1:0] FUNC_CODE      = 2'd1;
  localparam logic [1:0] FUNC_NEW_FRAME = 2'd2;

  // Opcode forms, top two bits of an opcode byte
  localparam logic [1:0] FORM_ALPHA   = 2'd0;
  localparam logic [1:0] FORM_LITERAL = 2'd1;
  localparam logic [1:0] FORM_IRUN    = 2'd2;
  localparam logic [1:0] FORM_SKIP    = 2'd3;

  typedef enum logic [1:0] {
    KIND_CLEAR,    // transparent, pixel reads zero
    KIND_PALETTE,  // opaque palette color
    KIND_ALPHA     // palette color scaled by a level
  } pix_kind_e;

  typedef struct packed {
    pix_kind_e  kind;
    logic [7:0] level;
  } pix_req_t;

endpackage

@@ sv/rlepsd_palette_ram.sv @@
// 256 x 16 RGB565 palette memory: one write port, one registered read port.
// Depends on rlepsd_pkg for depth and widths.
module rlepsd_palette_ram
  import rlepsd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [PAL_ADDR_W-1:0] waddr_i,
  input  logic [COLOR_W-1:0]    wdata_i,
  input  logic                  re_i,
  input  logic [PAL_ADDR_W-1:0] raddr_i,
  output logic [COLOR_W-1:0]    rdata_o
);

  logic [COLOR_W-1:0] mem_q [PAL_DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/rlepsd_pixel.sv @@
// Pixel formatter: alpha scaling of an RGB565 color and widening to ABGR8888.
// Depends on rlepsd_pkg for pix_req_t and widths.
module rlepsd_pixel
  import rlepsd_pkg::*;
(
  input  logic [COLOR_W-1:0] color_i,
  input  pix_req_t           req_i,
  output logic [PIX_W-1:0]   abgr_o
);

  function automatic logic [PIX_W-1:0] widen(input logic [15:0] c, input logic [7:0] a);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {a, b, b[4:2], g, g[5:4], r, r[4:2]};
  endfunction

  logic [12:0] r_prod;
  logic [13:0] g_prod;
  logic [12:0] b_prod;
  logic [15:0] mixed;

  assign r_prod = 13'(color_i[15:11]) * 13'(req_i.level);
  assign g_prod = 14'(color_i[10:5])  * 14'(req_i.level);
  assign b_prod = 13'(color_i[4:0])   * 13'(req_i.level);

  // Scaled channels overlap on purpose; only the low 16 bits survive
  assign mixed = {r_prod[9:5], 11'b0} | {2'b0, g_prod[13:5], 5'b0} | {8'b0, b_prod[12:5]};

  always_comb begin
    case (req_i.kind)
      KIND_PALETTE: abgr_o = widen(color_i, 8'hff);
      KIND_ALPHA:   abgr_o = widen(mixed, {req_i.level[4:0], 3'b000});
      default:      abgr_o = '0;
    endcase
  end

endmodule

@@ sv/rle_palette_sprite_line_decoder.sv @@
// Run-length palette sprite line decoder, top level.
// Depends on rlepsd_pkg, rlepsd_palette_ram and rlepsd_pixel.
// Path: a request's result is held in stage one, beside the registered palette read,
// and then in the output register, which drives m_axis.
// Throughput: one request per cycle while m_axis takes results; a stalled output holds stage one.
// Reset: rst_ni clears parse state, line width to 640 and both stages at once;
// the palette keeps no reset and reads undefined until written.
module rle_palette_sprite_line_decoder
  import rlepsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: line_width
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // code_byte[7:0], palette_slot[15:8],
                                           // palette_color[31:16]
  input  logic [1:0]        s_axis_tuser,  // func[1:0]
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // pixel_abgr[31:0], run_length[44:32], zero pad
  output logic [1:0]        m_axis_tuser,  // drawn[0], row_copy_hint[1]
  output logic              m_axis_tlast   // line_end
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_ALPHA1_INDEX,
    PH_ARUN_LEVEL,
    PH_ARUN_INDEX,
    PH_LITERAL,
    PH_IRUN_INDEX
  } phase_e;

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  logic [1:0]            func;
  logic [7:0]            code;
  logic [PAL_ADDR_W-1:0] slot;
  logic [COLOR_W-1:0]    color;
  logic                  accept;

  assign func   = s_axis_tuser;
  assign code   = s_axis_tdata[7:0];
  assign slot   = s_axis_tdata[15:8];
  assign color  = s_axis_tdata[31:16];
  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Parse state and stage-one registers
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] line_width_q;
  phase_e           phase_q, phase_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [7:0]       lvl_q, lvl_d;
  logic [LEN_W-1:0] done_q, done_d;
  logic [1:0]       row_q, row_d;
  logic             copy_q, copy_d;

  logic             s1_vld_q, s1_vld_d;
  logic [LEN_W-1:0] s1_len_q;
  logic             s1_drawn_q;
  logic             s1_end_q;
  logic             s1_copy_q;
  pix_req_t         s1_req_q;

  // Room left on the current line; widths above the maximum act as the maximum
  logic [LEN_W-1:0] width_cap;
  logic [LEN_W-1:0] room;

  assign width_cap = (line_width_q > LEN_W'(LINE_MAX)) ? LEN_W'(LINE_MAX) : line_width_q;
  assign room      = (done_q < width_cap) ? (width_cap - done_q) : '0;

  // Result produced by this request
  logic             emit;
  logic [LEN_W-1:0] e_len;
  logic             e_drawn;
  logic             e_end;
  pix_req_t         e_req;

  always_comb begin
    logic             run_req;
    logic [5:0]       run_n;
    logic [LEN_W-1:0] take;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    lvl_d   = lvl_q;
    done_d  = done_q;
    row_d   = row_q;
    copy_d  = copy_q;
    emit    = 1'b0;
    e_len   = '0;
    e_drawn = 1'b0;
    e_end   = 1'b0;
    e_req   = '{kind: KIND_CLEAR, level: 8'd0};
    run_req = 1'b0;
    run_n   = '0;

    if (accept) begin
      case (func)
        FUNC_NEW_FRAME: begin
          done_d  = '0;
          row_d   = '0;
          copy_d  = 1'b1;
          phase_d = PH_OPCODE;
          cnt_d   = '0;
          lvl_d   = '0;
        end
        FUNC_CODE: begin
          case (phase_q)
            PH_ALPHA1_INDEX: begin
              phase_d = PH_OPCODE;
              run_req = 1'b1;
              run_n   = 6'd1;
              e_req   = '{kind: KIND_ALPHA, level: lvl_q};
            end
            PH_ARUN_LEVEL: begin
              lvl_d   = code;
              phase_d = PH_ARUN_INDEX;
            end
            PH_ARUN_INDEX: begin
              phase_d = PH_OPCODE;
              run_req = 1'b1;
              run_n   = cnt_q;
              e_req   = '{kind: KIND_ALPHA, level: lvl_q};
            end
            PH_LITERAL: begin
              cnt_d   = cnt_q - 6'd1;
              if (cnt_d == '0) begin
                phase_d = PH_OPCODE;
              end
              run_req = 1'b1;
              run_n   = 6'd1;
              e_req   = '{kind: KIND_PALETTE, level: 8'd0};
            end
            PH_IRUN_INDEX: begin
              phase_d = PH_OPCODE;
              run_req = 1'b1;
              run_n   = cnt_q;
              e_req   = '{kind: KIND_PALETTE, level: 8'd0};
            end
            default: begin
              phase_d = PH_OPCODE;
              if (code == 8'd0) begin
                // End of line: close it with the room left, even if none
                emit   = 1'b1;
                e_len  = room;
                e_end  = 1'b1;
                done_d = '0;
                if (row_q < 2'd2) begin
                  row_d = row_q + 2'd1;
                end
              end else begin
                if (code[7:6] != FORM_SKIP && row_q == 2'd1) begin
                  copy_d = 1'b0;
                end
                case (code[7:6])
                  FORM_ALPHA: begin
                    if (code[5]) begin
                      lvl_d   = {3'b000, code[4:0]};
                      phase_d = PH_ALPHA1_INDEX;
                    end else begin
                      cnt_d   = {1'b0, code[4:0]};
                      phase_d = PH_ARUN_LEVEL;
                    end
                  end
                  FORM_LITERAL: begin
                    cnt_d = code[5:0];
                    if (code[5:0] != '0) begin
                      phase_d = PH_LITERAL;
                    end
                  end
                  FORM_IRUN: begin
                    cnt_d   = code[5:0];
                    phase_d = PH_IRUN_INDEX;
                  end
                  default: begin
                    cnt_d   = code[5:0];
                    run_req = 1'b1;
                    run_n   = code[5:0];
                  end
                endcase
              end
            end
          endcase
        end
        default: begin
          // Palette writes keep the parse state; unused codes are dropped
        end
      endcase
    end

    // Clamp a run to the room left; drop it when nothing fits
    take = (LEN_W'(run_n) < room) ? LEN_W'(run_n) : room;
    if (run_req && take != '0) begin
      emit    = 1'b1;
      e_len   = take;
      e_drawn = (e_req.kind != KIND_CLEAR);
      done_d  = done_q + take;
    end
  end

  // ---------------------------------------------------------------------------
  // Palette memory: write on palette requests, read on every coded byte
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] pal_rdata;

  rlepsd_palette_ram u_palette (
    .clk_i   (clk_i),
    .we_i    (accept && func == FUNC_PAL_WR),
    .waddr_i (slot),
    .wdata_i (color),
    .re_i    (accept && func == FUNC_CODE),
    .raddr_i (code),
    .rdata_o (pal_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output register; stage one advances into it whenever it is free
  // ---------------------------------------------------------------------------
  logic             out_ld;
  logic             out_vld_q;
  logic [PIX_W-1:0] out_pix_q;
  logic [LEN_W-1:0] out_len_q;
  logic             out_drawn_q;
  logic             out_end_q;
  logic             out_copy_q;
  logic [PIX_W-1:0] pix_abgr;

  assign out_ld        = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || out_ld;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (s_axis_tready) begin
      s1_vld_d = accept && emit;
    end
  end

  rlepsd_pixel u_pixel (
    .color_i (pal_rdata),
    .req_i   (s1_req_q),
    .abgr_o  (pix_abgr)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LEN_W'(LINE_RESET);
      phase_q      <= PH_OPCODE;
      cnt_q        <= '0;
      lvl_q        <= '0;
      done_q       <= '0;
      row_q        <= '0;
      copy_q       <= 1'b1;
      s1_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      lvl_q    <= lvl_d;
      done_q   <= done_d;
      row_q    <= row_d;
      copy_q   <= copy_d;
      s1_vld_q <= s1_vld_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: load stage one on an emitting request, then the output
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_len_q   <= e_len;
      s1_drawn_q <= e_drawn;
      s1_end_q   <= e_end;
      s1_copy_q  <= copy_d;
      s1_req_q   <= e_req;
    end
    if (out_ld) begin
      out_pix_q   <= pix_abgr;
      out_len_q   <= s1_len_q;
      out_drawn_q <= s1_drawn_q;
      out_end_q   <= s1_end_q;
      out_copy_q  <= s1_copy_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_len_q, out_pix_q};
  assign m_axis_tuser  = {out_copy_q, out_drawn_q};
  assign m_axis_tlast  = out_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= LEN_W'(LINE_MAX))
    else $error("pixel count ran past the widest line");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_ld |=> s1_vld_q && $stable(s1_len_q))
    else $error("stage one lost a stalled result");

  a_line_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func == FUNC_CODE && phase_q == PH_OPCODE && code == 8'd0
    |=> s1_vld_q && s1_end_q)
    else $error("end-of-line opcode gave no closing result");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_end_q |-> s1_len_q != '0)
    else $error("zero-length run reached stage one");

  a_clear_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_drawn_q |-> out_pix_q == '0)
    else $error("transparent result carries a nonzero pixel");

endmodule
